// File: rtl/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Implication that is also checked around reset
`define ASSERT_IMPLY_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("reset-time check failed");

`endif

// File: rtl/sspe_pkg.sv
package sspe_pkg;

    localparam logic [3:0] BIT_COUNT = 4'd8;
    localparam logic [7:0] X_MASK    = 8'h07;
    localparam logic [7:0] Y_MASK    = 8'h78;
    localparam logic [7:0] OUT_BYTE_RESET = 8'h06;

    typedef struct packed {
        logic sel_left_n;
        logic sel_below_n;
        logic mosi;
        logic sck;
    } pin_t;

    typedef struct packed {
        logic [7:0] address;
        logic       done_res;
        logic       miso;
    } result_t;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD_W  = OUT_DATA_W - $bits(result_t);

endpackage

// File: rtl/spi_slave_position_enumerator.sv
// SPI mode-0 slave that takes one transaction of sampled pin levels (sck, mosi and the two
// active-low selects) per clock while the output is not stalled and returns one transaction
// of miso, done_res and address for each. A new pin sample is accepted every cycle unless
// m_tready holds back a full result register; its result goes through the pin register and
// then the result register to the master side, with the whole edge-detect, shift and address
// update done in the single step between them. The first select to fall picks the side,
// with sel_below_n winning a tie, out_byte goes out MSB first, and the address is formed and
// done_res pulses when that select rises; the block then locks until reset.
module spi_slave_position_enumerator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [0] sck, [1] mosi, [2] sel_below_n, [3] sel_left_n, [7:4] zero
    input  logic [sspe_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] miso, [1] done_res, [9:2] address, [15:10] zero
    output logic [sspe_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [7:0]                           cfg_data
);
    import sspe_pkg::*;

    logic    pin_valid;
    pin_t    pin;
    result_t result;
    logic    out_free;
    logic    advance;

    assign advance   = pin_valid && out_free;
    assign cfg_ready = 1'b1;

    sspe_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .advance   (advance),
        .pin_valid (pin_valid),
        .pin       (pin)
    );

    sspe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .pin       (pin),
        .result    (result)
    );

    sspe_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/sspe_in_stage.sv
module sspe_in_stage (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sspe_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 advance,
    output logic                                 pin_valid,
    output sspe_pkg::pin_t                       pin
);
    import sspe_pkg::*;

    logic pin_valid_reg;
    logic pin_valid_next;
    pin_t pin_reg;

    assign s_tready = !pin_valid_reg || advance;

    always_comb
    begin
        pin_valid_next = pin_valid_reg;
        if (s_tready)
        begin
            pin_valid_next = s_tvalid;
        end
        else if (advance)
        begin
            pin_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_valid_reg <= 1'b0;
        end
        else
        begin
            pin_valid_reg <= pin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pin_reg <= pin_t'(s_tdata[$bits(pin_t)-1:0]);
        end
    end

    assign pin_valid = pin_valid_reg;
    assign pin       = pin_reg;

endmodule

// File: rtl/sspe_core.sv
module sspe_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    input  logic                advance,
    input  sspe_pkg::pin_t      pin,
    output sspe_pkg::result_t   result
);
    import sspe_pkg::*;

    typedef struct packed {
        logic [3:0] bits_left;
        logic       miso;
    } tx_t;

    function automatic tx_t send_bit(input logic [3:0] bits_left, input logic miso_in,
                                     input logic [7:0] byte_in);
        tx_t        r;
        logic [3:0] dec;
        dec         = bits_left - 4'd1;
        r.bits_left = bits_left;
        r.miso      = miso_in;
        if (bits_left != 4'd0 && bits_left <= BIT_COUNT)
        begin
            r.bits_left = dec;
            r.miso      = byte_in[dec[2:0]];
        end
        return r;
    endfunction

    logic [7:0] out_byte_reg;
    logic       prev_sck_reg, prev_sck_next;
    logic       prev_below_reg, prev_below_next;
    logic       prev_left_reg, prev_left_next;
    logic [3:0] tx_bits_reg, tx_bits_next;
    logic [3:0] rx_bits_reg, rx_bits_next;
    logic [7:0] rx_byte_reg, rx_byte_next;
    logic       hit_below_reg, hit_below_next;
    logic       hit_left_reg, hit_left_next;
    logic       locked_reg, locked_next;
    logic [7:0] addr_reg, addr_next;
    logic       miso_reg, miso_next;
    logic       done;

    logic       below_fall, below_rise, left_fall, left_rise;
    logic       sck_fall, sck_rise;
    logic       finish, trig_below, trig_left;
    tx_t        tx_first, tx_second;
    logic [3:0] rx_dec;
    logic [7:0] x_part, y_part;

    always_comb
    begin
        below_fall = prev_below_reg && !pin.sel_below_n;
        below_rise = !prev_below_reg && pin.sel_below_n;
        left_fall  = prev_left_reg && !pin.sel_left_n;
        left_rise  = !prev_left_reg && pin.sel_left_n;
        sck_fall   = prev_sck_reg && !pin.sck;
        sck_rise   = !prev_sck_reg && pin.sck;

        finish     = hit_below_reg ? below_rise : (hit_left_reg ? left_rise : 1'b0);
        trig_below = !hit_below_reg && !hit_left_reg && below_fall;
        trig_left  = !hit_below_reg && !hit_left_reg && !below_fall && left_fall;

        tx_first   = send_bit(tx_bits_reg, miso_reg, out_byte_reg);
        if (!(trig_below || trig_left))
        begin
            tx_first.bits_left = tx_bits_reg;
            tx_first.miso      = miso_reg;
        end
        tx_second  = send_bit(tx_first.bits_left, tx_first.miso, out_byte_reg);
        rx_dec     = rx_bits_reg - 4'd1;

        hit_below_next = hit_below_reg || trig_below;
        hit_left_next  = hit_left_reg || trig_left;
        x_part = (rx_byte_reg & X_MASK) + {7'd0, hit_left_next};
        y_part = (rx_byte_reg & Y_MASK) + {4'd0, hit_below_next, 3'd0};

        prev_sck_next   = prev_sck_reg;
        prev_below_next = prev_below_reg;
        prev_left_next  = prev_left_reg;
        tx_bits_next    = tx_bits_reg;
        rx_bits_next    = rx_bits_reg;
        rx_byte_next    = rx_byte_reg;
        locked_next     = locked_reg;
        addr_next       = addr_reg;
        miso_next       = miso_reg;
        done            = 1'b0;

        if (locked_reg)
        begin
            hit_below_next = hit_below_reg;
            hit_left_next  = hit_left_reg;
        end
        else
        begin
            prev_sck_next   = pin.sck;
            prev_below_next = pin.sel_below_n;
            prev_left_next  = pin.sel_left_n;
            tx_bits_next    = tx_first.bits_left;
            miso_next       = tx_first.miso;
            if (finish)
            begin
                addr_next    = addr_reg | x_part | y_part;
                tx_bits_next = BIT_COUNT;
                rx_bits_next = BIT_COUNT;
                locked_next  = 1'b1;
                done         = 1'b1;
            end
            else if (hit_below_next || hit_left_next)
            begin
                if (sck_fall)
                begin
                    tx_bits_next = tx_second.bits_left;
                    miso_next    = tx_second.miso;
                end
                else if (sck_rise && rx_bits_reg != 4'd0 && rx_bits_reg <= BIT_COUNT)
                begin
                    rx_bits_next = rx_dec;
                    rx_byte_next = rx_byte_reg | ({7'd0, pin.mosi} << rx_dec[2:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_byte_reg <= OUT_BYTE_RESET;
        end
        else if (cfg_valid)
        begin
            out_byte_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sck_reg   <= 1'b0;
            prev_below_reg <= 1'b1;
            prev_left_reg  <= 1'b1;
            tx_bits_reg    <= BIT_COUNT;
            rx_bits_reg    <= BIT_COUNT;
            rx_byte_reg    <= 8'd0;
            hit_below_reg  <= 1'b0;
            hit_left_reg   <= 1'b0;
            locked_reg     <= 1'b0;
            addr_reg       <= 8'd0;
            miso_reg       <= 1'b0;
        end
        else if (advance)
        begin
            prev_sck_reg   <= prev_sck_next;
            prev_below_reg <= prev_below_next;
            prev_left_reg  <= prev_left_next;
            tx_bits_reg    <= tx_bits_next;
            rx_bits_reg    <= rx_bits_next;
            rx_byte_reg    <= rx_byte_next;
            hit_below_reg  <= hit_below_next;
            hit_left_reg   <= hit_left_next;
            locked_reg     <= locked_next;
            addr_reg       <= addr_next;
            miso_reg       <= miso_next;
        end
    end

    assign result.miso     = miso_next;
    assign result.done_res = done;
    assign result.address  = addr_next;

endmodule

// File: rtl/sspe_out_stage.sv
module sspe_out_stage (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  sspe_pkg::result_t                    result,
    output logic                                 out_free,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sspe_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import sspe_pkg::*;

    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;

    assign out_free = !res_valid_reg || m_tready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_free)
        begin
            res_valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_reg};

endmodule

// File: rtl/sspe_checker.sv
`include "assert_macros.svh"

module sspe_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [sspe_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import sspe_pkg::*;

    `ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_IMPLY(a_done_addr, clk, rst_n, m_tvalid && m_tdata[1], m_tdata[9:2] != 8'd0)
    `ASSERT_IMPLY(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[OUT_DATA_W-1:10] == '0)
    `ASSERT_IMPLY_ALWAYS(a_reset_idle, clk, $rose(rst_n), !m_tvalid)

endmodule

bind spi_slave_position_enumerator sspe_checker u_sspe_checker (.*);
